@@ hw/rtl/tpas_pkg.sv @@
// Shared types and fixed widths of the three-point affine solver.
package tpas_pkg;

  localparam int CRD_W  = 24;  // point coordinate
  localparam int DIF_W  = 25;  // coordinate difference
  localparam int PRD_W  = 50;  // product of two differences
  localparam int DET_W  = 51;  // determinant and cofactor numerators
  localparam int MULH_W = 49;  // coordinate times upper numerator slice
  localparam int MULL_W = 51;  // coordinate times lower numerator slice
  localparam int SPL_W  = 26;  // width of the lower numerator slice
  localparam int MUL_W  = 75;  // full coordinate times numerator product
  localparam int NT_W   = 77;  // translation numerator
  localparam int COEF_W = 32;  // output coefficient
  localparam int SLV_LAT = 7;  // register stages ahead of the dividers
  localparam int DIV_LAT = COEF_W + 2;  // divider register stages

  typedef struct packed {
    logic signed [CRD_W-1:0] src0_x;
    logic signed [CRD_W-1:0] src0_y;
    logic signed [CRD_W-1:0] src1_x;
    logic signed [CRD_W-1:0] src1_y;
    logic signed [CRD_W-1:0] src2_x;
    logic signed [CRD_W-1:0] src2_y;
    logic signed [CRD_W-1:0] dst0_x;
    logic signed [CRD_W-1:0] dst0_y;
    logic signed [CRD_W-1:0] dst1_x;
    logic signed [CRD_W-1:0] dst1_y;
    logic signed [CRD_W-1:0] dst2_x;
    logic signed [CRD_W-1:0] dst2_y;
  } tpas_in_t;

  typedef struct packed {
    logic                     which_matrix;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_tx;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [COEF_W-1:0] coef_ty;
    logic                     degenerate;
    logic                     last_result;
  } tpas_out_t;

  // control that travels down the pipeline with each solve job
  typedef struct packed {
    logic valid;
    logic which;   // 0 forward solve, 1 inverse solve
    logic degen;   // a determinant is zero, coefficients forced to zero
  } tpas_tag_t;

endpackage

@@ hw/rtl/tpas_divider.sv @@
// Pipelined restoring divider: rounded, saturated signed 32-bit quotient.
module tpas_divider #(
  parameter int NW = 93,
  parameter int DW = 51
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [NW-1:0]                     num_i,
  input  logic [DW-1:0]                     den_i,
  input  logic                              neg_i,
  output logic signed [tpas_pkg::COEF_W-1:0] quo_o
);
  import tpas_pkg::*;

  localparam int QW = COEF_W;
  localparam int RW = (NW > DW + QW + 1) ? NW : DW + QW + 1;

  logic [RW-1:0] rem_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];
  logic signed [QW-1:0] quo_o_r;

  // entry: a quotient of 2^32 or more always saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(num_i);
      quo_r[0] <= '0;
      den_r[0] <= den_i;
      neg_r[0] <= neg_i;
      ovf_r[0] <= RW'(num_i) >= (RW'(den_i) << QW);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          fit;
    assign trial = RW'(den_r[k]) << (QW - 1 - k);
    assign fit   = rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= fit ? rem_r[k] - trial : rem_r[k];
        quo_r[k+1] <= {quo_r[k][QW-2:0], fit};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // round half away from zero, then clamp and apply sign
  logic          rnd;
  logic [QW:0]   sum;
  logic [QW:0]   lim;
  logic [QW-1:0] mag;

  always_comb begin
    rnd = {rem_r[QW], 1'b0} >= {1'b0, RW'(den_r[QW])};
    sum = {1'b0, quo_r[QW]} + (QW+1)'(rnd);
    lim = ((QW+1)'(1) << (QW - 1)) - (QW+1)'(!neg_r[QW]);
    mag = (ovf_r[QW] || (sum > lim)) ? lim[QW-1:0] : sum[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_o_r <= neg_r[QW] ? -mag : mag;
    end
  end

  assign quo_o = quo_o_r;

endmodule

@@ hw/rtl/tpas_solve.sv @@
// Cofactor front end: determinant, numerators and divider operands.
module tpas_solve #(
  parameter int CF = 8,
  parameter int KF = 16,
  parameter int NW = 93,
  parameter int DW = 51
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  tpas_pkg::tpas_tag_t               tag_i,
  input  logic signed [tpas_pkg::CRD_W-1:0] px [3],
  input  logic signed [tpas_pkg::CRD_W-1:0] py [3],
  input  logic signed [tpas_pkg::CRD_W-1:0] qx [3],
  input  logic signed [tpas_pkg::CRD_W-1:0] qy [3],
  output tpas_pkg::tpas_tag_t               tag_o,
  output logic [NW-1:0]                     num_o [6],
  output logic                              neg_o [6],
  output logic [DW-1:0]                     den_ab_o,
  output logic [DW-1:0]                     den_t_o
);
  import tpas_pkg::*;

  localparam int TN = (KF >= CF) ? KF - CF : 0;
  localparam int TD = (CF > KF) ? CF - KF : 0;

  // tag line, one entry per stage
  tpas_tag_t tag_r [SLV_LAT];
  logic      s3_degen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLV_LAT; s++) tag_r[s] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
      for (int s = 1; s < SLV_LAT; s++) begin
        if (s == 2) begin
          tag_r[s] <= {tag_r[1].valid, tag_r[1].which, s3_degen};
        end else begin
          tag_r[s] <= tag_r[s-1];
        end
      end
    end
  end

  // stage 1: differences against the first point
  logic signed [DIF_W-1:0] s1_dx2_r, s1_dy2_r, s1_dx3_r, s1_dy3_r;
  logic signed [DIF_W-1:0] s1_qx2_r, s1_qx3_r, s1_qy2_r, s1_qy3_r;
  logic signed [CRD_W-1:0] s1_p0x_r, s1_p0y_r, s1_q0x_r, s1_q0y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx2_r <= DIF_W'(px[1]) - DIF_W'(px[0]);
      s1_dy2_r <= DIF_W'(py[1]) - DIF_W'(py[0]);
      s1_dx3_r <= DIF_W'(px[2]) - DIF_W'(px[0]);
      s1_dy3_r <= DIF_W'(py[2]) - DIF_W'(py[0]);
      s1_qx2_r <= DIF_W'(qx[1]) - DIF_W'(qx[0]);
      s1_qx3_r <= DIF_W'(qx[2]) - DIF_W'(qx[0]);
      s1_qy2_r <= DIF_W'(qy[1]) - DIF_W'(qy[0]);
      s1_qy3_r <= DIF_W'(qy[2]) - DIF_W'(qy[0]);
      s1_p0x_r <= px[0];
      s1_p0y_r <= py[0];
      s1_q0x_r <= qx[0];
      s1_q0y_r <= qy[0];
    end
  end

  // stage 2: cross products of the differences
  logic signed [PRD_W-1:0] s2_pd0_r, s2_pd1_r, s2_qd0_r, s2_qd1_r;
  logic signed [PRD_W-1:0] s2_xa0_r, s2_xa1_r, s2_xb0_r, s2_xb1_r;
  logic signed [PRD_W-1:0] s2_ya0_r, s2_ya1_r, s2_yb0_r, s2_yb1_r;
  logic signed [CRD_W-1:0] s2_p0x_r, s2_p0y_r, s2_q0x_r, s2_q0y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pd0_r <= s1_dx2_r * s1_dy3_r;
      s2_pd1_r <= s1_dx3_r * s1_dy2_r;
      s2_qd0_r <= s1_qx2_r * s1_qy3_r;
      s2_qd1_r <= s1_qx3_r * s1_qy2_r;
      s2_xa0_r <= s1_qx2_r * s1_dy3_r;
      s2_xa1_r <= s1_qx3_r * s1_dy2_r;
      s2_xb0_r <= s1_dx2_r * s1_qx3_r;
      s2_xb1_r <= s1_dx3_r * s1_qx2_r;
      s2_ya0_r <= s1_qy2_r * s1_dy3_r;
      s2_ya1_r <= s1_qy3_r * s1_dy2_r;
      s2_yb0_r <= s1_dx2_r * s1_qy3_r;
      s2_yb1_r <= s1_dx3_r * s1_qy2_r;
      s2_p0x_r <= s1_p0x_r;
      s2_p0y_r <= s1_p0y_r;
      s2_q0x_r <= s1_q0x_r;
      s2_q0y_r <= s1_q0y_r;
    end
  end

  // stage 3: determinant, cofactor numerators, singularity test
  logic signed [DET_W-1:0] s3_det_r, s3_nax_r, s3_nbx_r, s3_nay_r, s3_nby_r;
  logic signed [CRD_W-1:0] s3_p0x_r, s3_p0y_r, s3_q0x_r, s3_q0y_r;

  // the inverse is also void when the source points are collinear
  assign s3_degen = (s2_pd0_r == s2_pd1_r) || (tag_r[1].which && (s2_qd0_r == s2_qd1_r));

  always_ff @(posedge clk) begin
    if (en) begin
      s3_det_r <= DET_W'(s2_pd0_r) - DET_W'(s2_pd1_r);
      s3_nax_r <= DET_W'(s2_xa0_r) - DET_W'(s2_xa1_r);
      s3_nbx_r <= DET_W'(s2_xb0_r) - DET_W'(s2_xb1_r);
      s3_nay_r <= DET_W'(s2_ya0_r) - DET_W'(s2_ya1_r);
      s3_nby_r <= DET_W'(s2_yb0_r) - DET_W'(s2_yb1_r);
      s3_p0x_r <= s2_p0x_r;
      s3_p0y_r <= s2_p0y_r;
      s3_q0x_r <= s2_q0x_r;
      s3_q0y_r <= s2_q0y_r;
    end
  end

  // stage 4: translation partial products, numerator split in two slices
  logic signed [CRD_W-1:0]  mul_a [6];
  logic signed [DET_W-1:0]  mul_v [6];
  logic signed [MULH_W-1:0] s4_hi_r [6];
  logic signed [MULL_W-1:0] s4_lo_r [6];
  logic signed [DET_W-1:0]  s4_det_r, s4_nax_r, s4_nbx_r, s4_nay_r, s4_nby_r;

  always_comb begin
    mul_a[0] = s3_q0x_r;  mul_v[0] = s3_det_r;
    mul_a[1] = s3_p0x_r;  mul_v[1] = s3_nax_r;
    mul_a[2] = s3_p0y_r;  mul_v[2] = s3_nbx_r;
    mul_a[3] = s3_q0y_r;  mul_v[3] = s3_det_r;
    mul_a[4] = s3_p0x_r;  mul_v[4] = s3_nay_r;
    mul_a[5] = s3_p0y_r;  mul_v[5] = s3_nby_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s4_hi_r[k] <= mul_a[k] * $signed(mul_v[k][DET_W-1:SPL_W]);
        s4_lo_r[k] <= mul_a[k] * $signed({1'b0, mul_v[k][SPL_W-1:0]});
      end
      s4_det_r <= s3_det_r;
      s4_nax_r <= s3_nax_r;
      s4_nbx_r <= s3_nbx_r;
      s4_nay_r <= s3_nay_r;
      s4_nby_r <= s3_nby_r;
    end
  end

  // stage 5: recombine the slices
  logic signed [MUL_W-1:0] s5_prd_r [6];
  logic signed [DET_W-1:0] s5_det_r, s5_nax_r, s5_nbx_r, s5_nay_r, s5_nby_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s5_prd_r[k] <= (MUL_W'(s4_hi_r[k]) <<< SPL_W) + MUL_W'(s4_lo_r[k]);
      end
      s5_det_r <= s4_det_r;
      s5_nax_r <= s4_nax_r;
      s5_nbx_r <= s4_nbx_r;
      s5_nay_r <= s4_nay_r;
      s5_nby_r <= s4_nby_r;
    end
  end

  // stage 6: translation numerators t0*det - na*x0 - nb*y0
  logic signed [NT_W-1:0]  s6_ntx_r, s6_nty_r;
  logic signed [DET_W-1:0] s6_det_r, s6_nax_r, s6_nbx_r, s6_nay_r, s6_nby_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ntx_r <= NT_W'(s5_prd_r[0]) - NT_W'(s5_prd_r[1]) - NT_W'(s5_prd_r[2]);
      s6_nty_r <= NT_W'(s5_prd_r[3]) - NT_W'(s5_prd_r[4]) - NT_W'(s5_prd_r[5]);
      s6_det_r <= s5_det_r;
      s6_nax_r <= s5_nax_r;
      s6_nbx_r <= s5_nbx_r;
      s6_nay_r <= s5_nay_r;
      s6_nby_r <= s5_nby_r;
    end
  end

  // stage 7: magnitudes, quotient signs and scaling
  logic [DET_W-1:0] mag_det, mag_nax, mag_nbx, mag_nay, mag_nby;
  logic [NT_W-1:0]  mag_ntx, mag_nty;
  logic             sd;

  always_comb begin
    sd      = s6_det_r[DET_W-1];
    mag_det = sd ? DET_W'(-s6_det_r) : DET_W'(s6_det_r);
    mag_nax = s6_nax_r[DET_W-1] ? DET_W'(-s6_nax_r) : DET_W'(s6_nax_r);
    mag_nbx = s6_nbx_r[DET_W-1] ? DET_W'(-s6_nbx_r) : DET_W'(s6_nbx_r);
    mag_nay = s6_nay_r[DET_W-1] ? DET_W'(-s6_nay_r) : DET_W'(s6_nay_r);
    mag_nby = s6_nby_r[DET_W-1] ? DET_W'(-s6_nby_r) : DET_W'(s6_nby_r);
    mag_ntx = s6_ntx_r[NT_W-1] ? NT_W'(-s6_ntx_r) : NT_W'(s6_ntx_r);
    mag_nty = s6_nty_r[NT_W-1] ? NT_W'(-s6_nty_r) : NT_W'(s6_nty_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o[0] <= NW'(mag_nax) << KF;
      num_o[1] <= NW'(mag_nbx) << KF;
      num_o[2] <= NW'(mag_ntx) << TN;
      num_o[3] <= NW'(mag_nay) << KF;
      num_o[4] <= NW'(mag_nby) << KF;
      num_o[5] <= NW'(mag_nty) << TN;
      neg_o[0] <= s6_nax_r[DET_W-1] ^ sd;
      neg_o[1] <= s6_nbx_r[DET_W-1] ^ sd;
      neg_o[2] <= s6_ntx_r[NT_W-1] ^ sd;
      neg_o[3] <= s6_nay_r[DET_W-1] ^ sd;
      neg_o[4] <= s6_nby_r[DET_W-1] ^ sd;
      neg_o[5] <= s6_nty_r[NT_W-1] ^ sd;
      den_ab_o <= DW'(mag_det);
      den_t_o  <= DW'(mag_det) << TD;
    end
  end

  assign tag_o = tag_r[SLV_LAT-1];

endmodule

@@ hw/rtl/three_point_affine_solve_unit.sv @@
// Top level of the three-point affine solver: job issue, dividers, output register.
//
// Each accepted request (three source and three destination points) yields two results: the
// forward source-to-destination matrix, then the inverse matrix, each coefficient rounded to
// nearest (ties away from zero) and saturated to signed 32 bits. Internally a request is issued
// as two solve jobs, forward then inverse, into one fully pipelined datapath, so a new request
// is taken at the earliest as the previous one issues its inverse job; job issue sets that pace.
// A job passes 7 cofactor stages, 34 divider stages and the output register; the inverse
// result follows the forward one. A stall while a result is held freezes the whole pipeline.
module three_point_affine_solve_unit #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int COEF_FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpas_pkg::tpas_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tpas_pkg::tpas_out_t out_data
);
  import tpas_pkg::*;

  localparam int TD = (COORD_FRAC_BITS > COEF_FRAC_BITS) ?
                      COORD_FRAC_BITS - COEF_FRAC_BITS : 0;
  localparam int NW = NT_W + COEF_FRAC_BITS;
  localparam int DW = DET_W + TD;

  logic en;
  logic out_valid_r;
  tpas_out_t out_data_r;

  // the whole pipeline advances unless a finished result is held
  assign en = !out_valid_r || !out_stall;

  // request buffer; issues the forward job, then the inverse job
  tpas_in_t buf_r;
  logic     buf_vld_r;
  logic     phase_r;
  logic     take;

  assign in_stall = buf_vld_r && !(en && phase_r);
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      phase_r   <= 1'b0;
    end else if (take) begin
      buf_vld_r <= 1'b1;
      phase_r   <= 1'b0;
    end else if (en && buf_vld_r) begin
      buf_vld_r <= !phase_r;
      phase_r   <= !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) buf_r <= in_data;
  end

  // job operands: the inverse maps the destination points back to the source
  logic signed [CRD_W-1:0] sx [3], sy [3], dx [3], dy [3];
  logic signed [CRD_W-1:0] px [3], py [3], qx [3], qy [3];
  tpas_tag_t job_tag;

  always_comb begin
    sx[0] = buf_r.src0_x;  sy[0] = buf_r.src0_y;
    sx[1] = buf_r.src1_x;  sy[1] = buf_r.src1_y;
    sx[2] = buf_r.src2_x;  sy[2] = buf_r.src2_y;
    dx[0] = buf_r.dst0_x;  dy[0] = buf_r.dst0_y;
    dx[1] = buf_r.dst1_x;  dy[1] = buf_r.dst1_y;
    dx[2] = buf_r.dst2_x;  dy[2] = buf_r.dst2_y;
    for (int k = 0; k < 3; k++) begin
      px[k] = phase_r ? dx[k] : sx[k];
      py[k] = phase_r ? dy[k] : sy[k];
      qx[k] = phase_r ? sx[k] : dx[k];
      qy[k] = phase_r ? sy[k] : dy[k];
    end
    job_tag.valid = buf_vld_r;
    job_tag.which = phase_r;
    job_tag.degen = 1'b0;
  end

  // cofactor front end
  tpas_tag_t      slv_tag;
  logic [NW-1:0]  num [6];
  logic           neg [6];
  logic [DW-1:0]  den_ab, den_t;

  tpas_solve #(
    .CF (COORD_FRAC_BITS),
    .KF (COEF_FRAC_BITS),
    .NW (NW),
    .DW (DW)
  ) u_solve (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .tag_i    (job_tag),
    .px       (px),
    .py       (py),
    .qx       (qx),
    .qy       (qy),
    .tag_o    (slv_tag),
    .num_o    (num),
    .neg_o    (neg),
    .den_ab_o (den_ab),
    .den_t_o  (den_t)
  );

  // six dividers, one per coefficient; translations use the scaled divisor
  logic signed [COEF_W-1:0] quo [6];

  for (genvar k = 0; k < 6; k++) begin : g_div
    tpas_divider #(
      .NW (NW),
      .DW (DW)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num[k]),
      .den_i ((k == 2 || k == 5) ? den_t : den_ab),
      .neg_i (neg[k]),
      .quo_o (quo[k])
    );
  end

  // tag line alongside the dividers
  tpas_tag_t tag_d_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_LAT; s++) tag_d_r[s] <= '0;
    end else if (en) begin
      tag_d_r[0] <= slv_tag;
      for (int s = 1; s < DIV_LAT; s++) tag_d_r[s] <= tag_d_r[s-1];
    end
  end

  // output register; a void matrix reads as zeros
  tpas_tag_t fin;
  assign fin = tag_d_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.which_matrix <= fin.which;
      out_data_r.coef_a       <= fin.degen ? '0 : quo[0];
      out_data_r.coef_b       <= fin.degen ? '0 : quo[1];
      out_data_r.coef_tx      <= fin.degen ? '0 : quo[2];
      out_data_r.coef_c       <= fin.degen ? '0 : quo[3];
      out_data_r.coef_d       <= fin.degen ? '0 : quo[4];
      out_data_r.coef_ty      <= fin.degen ? '0 : quo[5];
      out_data_r.degenerate   <= fin.degen;
      out_data_r.last_result  <= fin.which;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
